[design/jse_pkg.sv]
// Shared types, character constants and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_idx;

    localparam t_byte CHR_BACKSLASH = 8'h5C;
    localparam t_byte CHR_QUOTE     = 8'h22;
    localparam t_byte CHR_NEWLINE   = 8'h0A;
    localparam t_byte CHR_RETURN    = 8'h0D;
    localparam t_byte CHR_TAB       = 8'h09;
    localparam t_byte CHR_LOW_N     = 8'h6E;
    localparam t_byte CHR_LOW_R     = 8'h72;
    localparam t_byte CHR_LOW_T     = 8'h74;
    localparam t_byte CHR_LOW_U     = 8'h75;
    localparam t_byte CHR_ZERO      = 8'h30;
    localparam t_byte CHR_HEX_ALPHA = 8'h57;   // 'a' minus ten
    localparam t_byte CTRL_LIMIT    = 8'h20;

    // Position of each character within a unicode escape run.
    localparam t_idx IDX_SLASH = 3'd0;
    localparam t_idx IDX_U     = 3'd1;
    localparam t_idx IDX_ZERO0 = 3'd2;
    localparam t_idx IDX_ZERO1 = 3'd3;
    localparam t_idx IDX_HEXHI = 3'd4;
    localparam t_idx IDX_HEXLO = 3'd5;

    // One character of an escape run and whether it closes the run.
    typedef struct packed {
        t_byte chr;
        logic  last;
    } t_enc;

    // Lower-case hex digit for a nibble.
    function automatic t_byte hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHR_ZERO + {4'h0, nib};
        end else begin
            return CHR_HEX_ALPHA + {4'h0, nib};
        end
    endfunction

endpackage
`default_nettype wire

[design/jse_stream_if.sv]
// Valid/ready stream interfaces for the raw input bytes and the escaped output bytes.
`default_nettype none
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_string_end;

    modport source (output valid, output in_byte, output in_string_end, input ready);
    modport sink   (input valid, input in_byte, input in_string_end, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_string_end;

    modport source (output valid, output out_byte, output run_last,
                    output out_string_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input out_string_end, output ready);
endinterface
`default_nettype wire

[design/json_string_escaper_unit.sv]
// Top level of the JSON string escaper: input register, encoder and output register.
// A byte taken on the input passes through the input register and the output register before it appears on the output.
// A two-character escape and a six-character unicode escape are expanded by the single encoder,
// which emits one output character per cycle while the output register is free or being transferred.
// Reset (synchronous, active low) empties the input and output registers; no data is lost
// or produced for items that were not yet accepted.
`default_nettype none
module json_string_escaper_unit (
    input  wire       i_clk,
    input  wire       i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);
    import jse_pkg::*;

    // Input register: the raw byte being expanded and the position within its run.
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_end;
    t_idx  r_idx;
    t_idx  n_idx;

    // Output register: one escaped character waiting for its transfer.
    logic  r_out_valid;
    t_byte r_out_byte;
    logic  r_out_last;
    logic  r_out_end;

    t_enc  enc;
    logic  advance;
    logic  run_done;
    logic  take_in;

    jse_encoder u_encoder (
        .i_byte (r_in_byte),
        .i_idx  (r_idx),
        .o_enc  (enc)
    );

    // A character moves into the output register whenever that register is empty or its
    // current content is transferred in this same cycle.
    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign run_done = advance && enc.last;

    // The input register frees up as soon as the last character of its run is issued, so
    // a new byte is taken in the same cycle and plain bytes stream at full rate while the output accepts.
    assign i_in.ready = !r_in_valid || run_done;
    assign take_in    = i_in.valid && i_in.ready;

    assign n_idx = r_idx + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= IDX_SLASH;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
                r_idx      <= IDX_SLASH;
            end else if (run_done) begin
                r_in_valid <= 1'b0;
                r_idx      <= IDX_SLASH;
            end else if (advance) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.in_string_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The end-of-string flag rides only on the closing character of a run.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= enc.chr;
            r_out_last <= enc.last;
            r_out_end  <= enc.last && r_in_end;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.run_last       = r_out_last;
    assign o_out.out_string_end = r_out_end;

endmodule
`default_nettype wire

[design/jse_encoder.sv]
// Combinational lookup of one character of the escape run for a raw byte.
`default_nettype none
module jse_encoder (
    input  wire jse_pkg::t_byte i_byte,
    input  wire jse_pkg::t_idx  i_idx,
    output jse_pkg::t_enc       o_enc
);
    import jse_pkg::*;

    logic  short_esc;
    t_byte short_chr;
    logic  ctrl_esc;
    t_byte ctrl_chr;

    always_comb begin
        short_esc = 1'b1;
        short_chr = i_byte;
        case (i_byte)
            CHR_QUOTE:     short_chr = CHR_QUOTE;
            CHR_BACKSLASH: short_chr = CHR_BACKSLASH;
            CHR_NEWLINE:   short_chr = CHR_LOW_N;
            CHR_RETURN:    short_chr = CHR_LOW_R;
            CHR_TAB:       short_chr = CHR_LOW_T;
            default:       short_esc = 1'b0;
        endcase
    end

    assign ctrl_esc = (i_byte < CTRL_LIMIT);

    always_comb begin
        unique case (i_idx) inside
            IDX_SLASH:            ctrl_chr = CHR_BACKSLASH;
            IDX_U:                ctrl_chr = CHR_LOW_U;
            IDX_ZERO0, IDX_ZERO1: ctrl_chr = CHR_ZERO;
            IDX_HEXHI:            ctrl_chr = hex_digit(i_byte[7:4]);
            IDX_HEXLO:            ctrl_chr = hex_digit(i_byte[3:0]);
            default:              ctrl_chr = CHR_ZERO;
        endcase
    end

    always_comb begin
        if (short_esc) begin
            o_enc.chr  = (i_idx == IDX_SLASH) ? CHR_BACKSLASH : short_chr;
            o_enc.last = (i_idx == IDX_U);
        end else if (ctrl_esc) begin
            o_enc.chr  = ctrl_chr;
            o_enc.last = (i_idx == IDX_HEXLO);
        end else begin
            o_enc.chr  = i_byte;
            o_enc.last = 1'b1;
        end
    end

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the JSON string escaper: random stalls on both sides.
module testbench;
    import jse_pkg::*;

    // The watchdog gives up after this many cycles with no transfer on either side.
    localparam int STALL_LIMIT  = 3000;
    // Total number of raw bytes and the point where both sides stop idling.
    localparam int TOTAL_BYTES  = 270;
    localparam int CALM_FROM    = 230;
    // The sender waits for the output to drain once, after this many bytes.
    localparam int DRAIN_AT     = 120;
    localparam t_byte CHR_LOWER_A = 8'h61;

    // One escaped output byte as it should appear on the output channel.
    typedef struct packed {
        t_byte chr;
        logic  run_last;
        logic  string_end;
    } t_escaped_char;

    // Keeps the escaped bytes still owed by the block, oldest first, and checks each
    // output transfer against the head of that queue.
    class t_escape_scoreboard;
        t_escaped_char pending_chars[$];
        int            error_count;

        function new();
            error_count = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            error_count++;
        endtask

        static function t_byte lower_hex(logic [3:0] nib);
            if (nib < 4'd10) begin
                return CHR_ZERO + t_byte'(nib);
            end
            return CHR_LOWER_A + t_byte'(nib) - 8'd10;
        endfunction

        // Works out the escape run of one raw byte and queues it.
        function void note_input(t_byte raw, logic str_end);
            t_byte         run_chars[6];
            int            run_len;
            t_escaped_char item;
            run_len = 2;
            run_chars[0] = CHR_BACKSLASH;
            case (raw)
                CHR_QUOTE:     run_chars[1] = CHR_QUOTE;
                CHR_BACKSLASH: run_chars[1] = CHR_BACKSLASH;
                CHR_NEWLINE:   run_chars[1] = CHR_LOW_N;
                CHR_RETURN:    run_chars[1] = CHR_LOW_R;
                CHR_TAB:       run_chars[1] = CHR_LOW_T;
                default: begin
                    if (raw < CTRL_LIMIT) begin
                        run_len = 6;
                        run_chars[1] = CHR_LOW_U;
                        run_chars[2] = CHR_ZERO;
                        run_chars[3] = CHR_ZERO;
                        run_chars[4] = lower_hex(raw[7:4]);
                        run_chars[5] = lower_hex(raw[3:0]);
                    end else begin
                        run_len = 1;
                        run_chars[0] = raw;
                    end
                end
            endcase
            for (int i = 0; i < run_len; i++) begin
                item.chr        = run_chars[i];
                item.run_last   = (i == run_len - 1);
                item.string_end = (i == run_len - 1) && str_end;
                pending_chars.push_back(item);
            end
        endfunction

        task check_output(t_byte chr, logic run_last, logic string_end);
            t_escaped_char want;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected byte %h (last %b, end %b)", chr, run_last,
                                 string_end));
            end else begin
                want = pending_chars.pop_front();
                if (chr !== want.chr) begin
                    report($sformatf("byte %h, expected %h", chr, want.chr));
                end
                if (run_last !== want.run_last) begin
                    report($sformatf("run_last %b, expected %b on byte %h", run_last,
                                     want.run_last, want.chr));
                end
                if (string_end !== want.string_end) begin
                    report($sformatf("out_string_end %b, expected %b on byte %h",
                                     string_end, want.string_end, want.chr));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    jse_in_if  in_ch ();
    jse_out_if out_ch ();

    json_string_escaper_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_escape_scoreboard escapes = new();

    // Idling switches for the two sides, and the running count of raw bytes sent.
    bit sender_idle_on;
    bit sink_idle_on;
    int bytes_sent;
    int quiet_cycles;
    int sink_stall_left;

    // The clock starts low, so the first rising edge lands at half a period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, before the block's registers move.
    // The input side is noted first; its output comes only after the input and output registers, so
    // the order within this block never pairs a result with its own input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                escapes.note_input(in_ch.in_byte, in_ch.in_string_end);
            end
            if (out_ch.valid && out_ch.ready) begin
                escapes.check_output(out_ch.out_byte, out_ch.run_last,
                                     out_ch.out_string_end);
            end
        end
        // A long run of cycles without any transfer means the block has hung.
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver holds ready high and, while idling is allowed, drops it now and then
    // for a burst of random length. Every change happens at the falling edge.
    initial begin
        out_ch.ready    = 1'b0;
        sink_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_left != 0) begin
                out_ch.ready <= 1'b0;
                sink_stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                    sink_stall_left = $urandom_range(1, 14);
                end
            end
        end
    end

    // Sends one raw byte. The task is entered at a falling edge and returns at the
    // falling edge after the transfer, so valid stays high across back-to-back bytes
    // and gets a single assignment per time step.
    task automatic send_byte(t_byte raw, logic str_end);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= raw;
        in_ch.in_string_end <= str_end;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Random raw byte, weighted so that escapes are frequent next to plain text.
    function automatic t_byte pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_byte'($urandom_range(8'h20, 8'h7E));
            3, 4:    return t_byte'($urandom_range(8'h00, 8'h1F));
            5: begin
                case ($urandom_range(0, 4))
                    0:       return CHR_QUOTE;
                    1:       return CHR_BACKSLASH;
                    2:       return CHR_NEWLINE;
                    3:       return CHR_RETURN;
                    default: return CHR_TAB;
                endcase
            end
            6, 7:    return t_byte'($urandom_range(8'h80, 8'hFF));
            8:       return 8'h7F;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    // One string of 1 to 12 bytes, ended by the flag on its last byte. About one in
    // ten strings carries the end flag at random places instead.
    task automatic send_string();
        int  len;
        bit  noisy;
        logic str_end;
        len   = $urandom_range(1, 12);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            str_end = noisy ? logic'($urandom_range(0, 1)) : (i == len - 1);
            send_byte(pick_char(), str_end);
        end
    endtask

    // Directed bytes: field extremes, each named escape, unicode escapes with both
    // digit kinds, the end flag on escaped bytes, and consecutive end flags.
    t_byte directed_chars[] = '{8'h00, 8'h1F, 8'hFF, 8'h80, 8'h7F, 8'h20, CHR_QUOTE,
                                CHR_BACKSLASH, CHR_NEWLINE, CHR_RETURN, CHR_TAB, 8'h01,
                                8'h1A, 8'h0B, 8'h08, 8'h41, CHR_QUOTE, CHR_BACKSLASH,
                                8'h10, 8'h7E, 8'hC3, CHR_TAB, 8'h0F, 8'h61};
    logic  directed_ends[] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                               1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    initial begin
        bit drained;
        drained             = 1'b0;
        bytes_sent          = 0;
        quiet_cycles        = 0;
        sender_idle_on      = 1'b1;
        sink_idle_on        = 1'b1;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'h00;
        in_ch.in_string_end = 1'b0;

        // Synchronous reset held low at the start and released at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_chars[i]) begin
            send_byte(directed_chars[i], directed_ends[i]);
        end

        // Random strings. Each string picks whether the two sides may idle, which leaves
        // stretches of full-rate traffic in between the stalled ones.
        while (bytes_sent < CALM_FROM) begin
            sender_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on   = ($urandom_range(0, 3) != 0);
            if (!drained && bytes_sent >= DRAIN_AT) begin
                // Let the block empty completely before going on.
                drained = 1'b1;
                in_ch.valid <= 1'b0;
                while (escapes.pending_chars.size() != 0) @(negedge i_clk);
            end
            send_string();
        end

        // The last part runs with no idling on either side.
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        while (bytes_sent < TOTAL_BYTES) begin
            send_string();
        end
        in_ch.valid <= 1'b0;

        // Wait for every owed byte; the watchdog catches a block that never delivers.
        while (escapes.pending_chars.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (escapes.pending_chars.size() != 0) begin
            escapes.report($sformatf("%0d escaped bytes never arrived",
                                     escapes.pending_chars.size()));
        end

        if (escapes.error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
